/* hdl/yrgb_pkg.sv */
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared constants and stage payload types for the YUYV to RGB888 converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int PIX_W  = 8;
  localparam int FRAC_W = 16;
  localparam int COEF_W = 18;   // 17 magnitude bits plus a zero sign bit
  localparam int SUM_W  = 26;   // holds base + any product without overflow

  // Coefficients, 16 fraction bits, rounded to nearest
  localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd89831;
  localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd45744;
  localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22127;
  localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd113538;

  localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'h80;
  localparam logic [PIX_W-1:0] CHAN_MAX    = 8'd255;
  localparam logic [PIX_W-1:0] SCALE_MUL   = 8'd220;

  typedef logic signed [SUM_W-1:0] sum_t;

  // After the multiply stage
  typedef struct packed {
    logic [PIX_W-1:0] y_first;
    logic [PIX_W-1:0] y_second;
    sum_t             prod_rv;
    sum_t             prod_gv;
    sum_t             prod_gu;
    sum_t             prod_bu;
    logic             last;
  } prod_t;

  // After the sum stage
  typedef struct packed {
    sum_t red_first;
    sum_t green_first;
    sum_t blue_first;
    sum_t red_second;
    sum_t green_second;
    sum_t blue_second;
    logic last;
  } sums_t;

  // Final pixel pair
  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
    logic             last;
  } rgb_t;

endpackage

/* hdl/yrgb_if.sv */
// ----------------------------------------------------------------------------
// yrgb_in_if / yrgb_out_if
// Valid/ready channels for YUYV macropixels and RGB888 pixel pairs.
// ----------------------------------------------------------------------------
interface yrgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] y_first;
  logic [7:0] u_chroma;
  logic [7:0] y_second;
  logic [7:0] v_chroma;
  logic       in_last;

  modport source (output valid, output y_first, output u_chroma, output y_second,
                  output v_chroma, output in_last, input ready);
  modport sink   (input valid, input y_first, input u_chroma, input y_second,
                  input v_chroma, input in_last, output ready);
endinterface

interface yrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;
  logic       out_last;

  modport source (output valid, output red_first, output green_first,
                  output blue_first, output red_second, output green_second,
                  output blue_second, output out_last, input ready);
  modport sink   (input valid, input red_first, input green_first,
                  input blue_first, input red_second, input green_second,
                  input blue_second, input out_last, output ready);
endinterface

/* hdl/yuyv_to_rgb888_core.sv */
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_core
// YUYV 4:2:2 macropixel to two RGB888 pixels sharing chroma, scaled by 220/256.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_ch   | in  | valid/ready          | y_first, u_chroma, y_second, v_chroma, in_last
//  out_ch  | out | valid/ready          | red/green/blue _first/_second, out_last
//
//  Three register stages: chroma multiply, luma sum, clamp and scale.
//  One transaction per cycle while out_ch is ready.
//  Each stage holds its own valid bit and takes new data when empty or when
//  the next stage takes its contents, so a stall on out_ch backs up without
//  loss. Synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_core (
  input  logic   clk,
  input  logic   rst_n,
  yrgb_in_if.sink    in_ch,
  yrgb_out_if.source out_ch
);
  import yrgb_pkg::*;

  logic  mul_valid;
  logic  mul_ready;
  prod_t mul_data;
  logic  sum_valid;
  logic  sum_ready;
  sums_t sum_data;
  rgb_t  rgb_data;

  yrgb_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .y_first  (in_ch.y_first),
    .u_chroma (in_ch.u_chroma),
    .y_second (in_ch.y_second),
    .v_chroma (in_ch.v_chroma),
    .last     (in_ch.in_last),
    .dn_valid (mul_valid),
    .dn_ready (mul_ready),
    .dn_data  (mul_data)
  );

  yrgb_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_ready (mul_ready),
    .up_data  (mul_data),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  yrgb_finish_stage u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (rgb_data)
  );

  assign out_ch.red_first    = rgb_data.red_first;
  assign out_ch.green_first  = rgb_data.green_first;
  assign out_ch.blue_first   = rgb_data.blue_first;
  assign out_ch.red_second   = rgb_data.red_second;
  assign out_ch.green_second = rgb_data.green_second;
  assign out_ch.blue_second  = rgb_data.blue_second;
  assign out_ch.out_last     = rgb_data.last;

endmodule

/* hdl/yrgb_mul_stage.sv */
// ----------------------------------------------------------------------------
// yrgb_mul_stage
// Removes the chroma bias and forms the four chroma products.
// ----------------------------------------------------------------------------
module yrgb_mul_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [7:0]          y_first,
  input  logic [7:0]          u_chroma,
  input  logic [7:0]          y_second,
  input  logic [7:0]          v_chroma,
  input  logic                last,
  output logic                dn_valid,
  input  logic                dn_ready,
  output yrgb_pkg::prod_t     dn_data
);
  import yrgb_pkg::*;

  logic                    valid_r;
  prod_t                   data_r;
  prod_t                   data_nxt;
  logic signed [PIX_W-1:0] du;
  logic signed [PIX_W-1:0] dv;

  assign up_ready = !valid_r || dn_ready;

  // c - 128 is the byte with its top bit flipped, read as two's complement
  assign du = $signed(u_chroma ^ CHROMA_BIAS);
  assign dv = $signed(v_chroma ^ CHROMA_BIAS);

  always_comb begin
    data_nxt.y_first  = y_first;
    data_nxt.y_second = y_second;
    data_nxt.prod_rv  = SUM_W'(dv) * SUM_W'(COEF_RV);
    data_nxt.prod_gv  = SUM_W'(dv) * SUM_W'(COEF_GV);
    data_nxt.prod_gu  = SUM_W'(du) * SUM_W'(COEF_GU);
    data_nxt.prod_bu  = SUM_W'(du) * SUM_W'(COEF_BU);
    data_nxt.last     = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* hdl/yrgb_sum_stage.sv */
// ----------------------------------------------------------------------------
// yrgb_sum_stage
// Adds the chroma products to the scaled luma for red and blue and subtracts them for green, for both pixels.
// ----------------------------------------------------------------------------
module yrgb_sum_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  yrgb_pkg::prod_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output yrgb_pkg::sums_t  dn_data
);
  import yrgb_pkg::*;

  logic  valid_r;
  sums_t data_r;
  sums_t data_nxt;
  sum_t  base0;
  sum_t  base1;

  assign up_ready = !valid_r || dn_ready;

  // luma in the same 16 fraction bit format, never negative
  assign base0 = $signed({2'b00, up_data.y_first, {FRAC_W{1'b0}}});
  assign base1 = $signed({2'b00, up_data.y_second, {FRAC_W{1'b0}}});

  always_comb begin
    data_nxt.red_first    = base0 + up_data.prod_rv;
    data_nxt.green_first  = base0 - up_data.prod_gv - up_data.prod_gu;
    data_nxt.blue_first   = base0 + up_data.prod_bu;
    data_nxt.red_second   = base1 + up_data.prod_rv;
    data_nxt.green_second = base1 - up_data.prod_gv - up_data.prod_gu;
    data_nxt.blue_second  = base1 + up_data.prod_bu;
    data_nxt.last         = up_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* hdl/yrgb_finish_stage.sv */
// ----------------------------------------------------------------------------
// yrgb_finish_stage
// Truncates, clamps to 0..255 and scales by 220/256; holds the output register.
// ----------------------------------------------------------------------------
module yrgb_finish_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  yrgb_pkg::sums_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output yrgb_pkg::rgb_t   dn_data
);
  import yrgb_pkg::*;

  logic valid_r;
  rgb_t data_r;
  rgb_t data_nxt;

  function automatic logic [PIX_W-1:0] finish_chan(input sum_t sum);
    logic [SUM_W-FRAC_W-2:0] whole;
    logic [PIX_W-1:0]        clamped;
    logic [2*PIX_W-1:0]      scaled;
    whole = sum[SUM_W-2:FRAC_W];
    if (sum[SUM_W-1]) begin
      clamped = '0;        // any negative sum, fractions included
    end else if (whole > (SUM_W-FRAC_W-1)'(CHAN_MAX)) begin
      clamped = CHAN_MAX;
    end else begin
      clamped = whole[PIX_W-1:0];
    end
    scaled = clamped * SCALE_MUL;
    return scaled[2*PIX_W-1:PIX_W];
  endfunction

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt.red_first    = finish_chan(up_data.red_first);
    data_nxt.green_first  = finish_chan(up_data.green_first);
    data_nxt.blue_first   = finish_chan(up_data.blue_first);
    data_nxt.red_second   = finish_chan(up_data.red_second);
    data_nxt.green_second = finish_chan(up_data.green_second);
    data_nxt.blue_second  = finish_chan(up_data.blue_second);
    data_nxt.last         = up_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
